// ===== sv/nppsched_pkg.sv =====
// Types and constants shared by the priority scheduler modules.
package nppsched_pkg;

  localparam logic [15:0] MAX_DISPATCH_RST = 16'd500;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam logic [1:0] STATUS_DISPATCHED = 2'd0;
  localparam logic [1:0] STATUS_REJ_FULL   = 2'd1;
  localparam logic [1:0] STATUS_REJ_LIMIT  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] job_id;
    logic [31:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  prio_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_job_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] wait_time;
    logic [31:0] turnaround_time;
    logic [47:0] total_wait;
    logic [47:0] total_turnaround;
    logic [15:0] dispatched_count;
    logic        last;
  } out_word_t;

  // One ready-queue entry.
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [7:0]  level;
  } q_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_POP,
    CELL_INSERT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fsm_state_t;

endpackage

// ===== sv/nonpreemptive_priority_scheduler_top.sv =====
// Top level of the non-preemptive priority scheduler: control, queue chain, results.
//
//  channel   dir  handshake                 word
//  --------  ---  ------------------------  -------------------------------
//  item      in   start & !busy             in_word_t (arrival or drain)
//  result    out  result_valid, one cycle   out_word_t (dispatch / reject)
//  config    in   cfg_we                    cfg_wdata -> max_dispatches
//
// An arrival or drain that is taken dispatches its jobs one after the other, then
// closes (for an arrival: jump of the idle clock, insert into the chain or
// queue-full reject). Each result is registered and shows in the cycle after the cycle that made it.
// An arrival refused by the dispatch limit is answered the cycle after it is
// taken and leaves busy low. One job leaves the head cell per cycle.
// Reset (rst, synchronous) empties the queue, zeroes clock, totals and count and
// loads max_dispatches with 500. Results cannot be stalled by the receiver.
module nonpreemptive_priority_scheduler_top
  import nppsched_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item,
  output logic      result_valid,
  output out_word_t result,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fsm_state_t state, state_next;
  in_word_t   item_q;

  logic [CW-1:0] count;
  logic [31:0]   clock_now;
  logic [47:0]   sum_wait;
  logic [47:0]   sum_turnaround;
  logic [15:0]   done_count;
  logic [15:0]   max_dispatches;

  // Queue chain: index 0 is the head (next job to run).
  q_entry_t entries     [QUEUE_DEPTH];
  q_entry_t left_e      [QUEUE_DEPTH];
  q_entry_t right_e     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ahead;
  logic [QUEUE_DEPTH-1:0] left_b;
  q_entry_t new_entry;
  cell_op_t cell_op;

  // Control strobes.
  logic do_dispatch, do_rej_limit, do_rej_full, do_insert, do_jump;

  // Dispatch datapath on the head entry.
  logic [31:0] end_t, wait_t, ta_t;
  logic        queue_empty, queue_full, limit_hit, clock_behind, run_go, last_disp;

  assign new_entry.id      = item_q.job_id;
  assign new_entry.arrival = item_q.arrival_time;
  assign new_entry.burst   = item_q.burst_length;
  assign new_entry.level   = item_q.prio_level;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      // Head cell: nothing ahead of it, so an insert that reaches it loads the new job.
      assign left_e[g] = new_entry;
      assign left_b[g] = 1'b0;
    end else begin : g_mid
      assign left_e[g] = entries[g-1];
      assign left_b[g] = ahead[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e[g] = entries[g];
    end else begin : g_body
      assign right_e[g] = entries[g+1];
    end

    nppsched_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .occ        (CW'(g) < count),
      .new_entry  (new_entry),
      .left_entry (left_e[g]),
      .left_ahead (left_b[g]),
      .right_entry(right_e[g]),
      .entry      (entries[g]),
      .ahead      (ahead[g])
    );
  end

  assign end_t  = clock_now + 32'(entries[0].burst);
  assign wait_t = clock_now - entries[0].arrival;
  assign ta_t   = end_t - entries[0].arrival;

  assign queue_empty  = (count == '0);
  assign queue_full   = (count == CW'(QUEUE_DEPTH));
  assign limit_hit    = (done_count >= max_dispatches);
  assign clock_behind = (clock_now < item_q.arrival_time);
  assign run_go       = !queue_empty && !limit_hit &&
                        ((item_q.cmd == CMD_DRAIN) || clock_behind);

  // Final dispatch of this word: queue runs dry, limit is hit, or (arrival)
  // the clock catches up. After any dispatch the queue cannot be full, so an
  // arrival's closing cycle inserts silently.
  assign last_disp = (count == CW'(1)) || ((done_count + 16'd1) == max_dispatches) ||
                     ((item_q.cmd == CMD_ARRIVE) && !(end_t < item_q.arrival_time));

  assign busy = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cell_op      = CELL_HOLD;
    do_dispatch  = 1'b0;
    do_rej_limit = 1'b0;
    do_rej_full  = 1'b0;
    do_insert    = 1'b0;
    do_jump      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if ((item.cmd == CMD_ARRIVE) && limit_hit) begin
            do_rej_limit = 1'b1;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (run_go) begin
          do_dispatch = 1'b1;
          cell_op     = CELL_POP;
        end else begin
          state_next = ST_IDLE;
          if (item_q.cmd == CMD_ARRIVE) begin
            do_jump = queue_empty && clock_behind;
            if (queue_full) begin
              do_rej_full = 1'b1;
            end else begin
              do_insert = 1'b1;
              cell_op   = CELL_INSERT;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      clock_now      <= '0;
      sum_wait       <= '0;
      sum_turnaround <= '0;
      done_count     <= '0;
      max_dispatches <= MAX_DISPATCH_RST;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= do_dispatch || do_rej_limit || do_rej_full;
      if (cfg_we) begin
        max_dispatches <= cfg_wdata;
      end
      if (do_dispatch) begin
        count          <= count - CW'(1);
        clock_now      <= end_t;
        sum_wait       <= sum_wait + 48'(wait_t);
        sum_turnaround <= sum_turnaround + 48'(ta_t);
        done_count     <= done_count + 16'd1;
      end
      if (do_insert) begin
        count <= count + CW'(1);
      end
      if (do_jump) begin
        clock_now <= item_q.arrival_time;
      end
    end
  end

  // Payload: latched word and result word.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      item_q <= item;
    end
    if (do_dispatch) begin
      result.status           <= STATUS_DISPATCHED;
      result.out_job_id       <= entries[0].id;
      result.start_time       <= clock_now;
      result.end_time         <= end_t;
      result.wait_time        <= wait_t;
      result.turnaround_time  <= ta_t;
      result.total_wait       <= sum_wait + 48'(wait_t);
      result.total_turnaround <= sum_turnaround + 48'(ta_t);
      result.dispatched_count <= done_count + 16'd1;
      result.last             <= last_disp;
    end else if (do_rej_limit || do_rej_full) begin
      result.status           <= do_rej_limit ? STATUS_REJ_LIMIT : STATUS_REJ_FULL;
      result.out_job_id       <= do_rej_limit ? item.job_id : item_q.job_id;
      result.start_time       <= '0;
      result.end_time         <= '0;
      result.wait_time        <= '0;
      result.turnaround_time  <= '0;
      result.total_wait       <= sum_wait;
      result.total_turnaround <= sum_turnaround;
      result.dispatched_count <= done_count;
      result.last             <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_DISPATCHED) |-> count == $past(count) - CW'(1))
    else $error("dispatch did not pop the queue");

  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STATUS_DISPATCHED) |-> !busy && result.last)
    else $error("reject not final or block still busy");

  a_accept_react: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("accepted word produced no activity");
`endif

endmodule

// ===== sv/nppsched_cell.sv =====
// One slot of the sorted ready queue; shifts toward the head on pop, away on insert.
module nppsched_cell
  import nppsched_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     occ,
  input  q_entry_t new_entry,
  input  q_entry_t left_entry,
  input  logic     left_ahead,
  input  q_entry_t right_entry,
  output q_entry_t entry,
  output logic     ahead
);

  // Occupied and not later in order than the incoming job: stays in place.
  assign ahead = occ && (entry.level <= new_entry.level);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_POP: begin
        entry <= right_entry;
      end
      CELL_INSERT: begin
        if (!ahead) begin
          entry <= left_ahead ? new_entry : left_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/nonpreemptive_priority_scheduler_top_tb.sv =====
// Self-checking testbench of the non-preemptive priority scheduler: directed and random words.
module nonpreemptive_priority_scheduler_top_tb
  import nppsched_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 8;
  localparam int RST_CYCLES     = 8;
  localparam int QUEUE_DEPTH    = 16;
  // Longest busy stretch is one word dispatching a full queue plus its closing cycle.
  localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // DUT hookup; every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    item = '0;
  logic        result_valid;
  out_word_t   result;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  nonpreemptive_priority_scheduler_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Words waiting for the driver, and results the scheduler still owes us.
  in_word_t  req_q[$];
  out_word_t dispatch_exp_q[$];

  // Shadow copy of the scheduler state.
  logic [31:0] sim_clock;
  logic [47:0] sim_wait_sum;
  logic [47:0] sim_ta_sum;
  logic [15:0] sim_done;
  logic [15:0] sim_limit;
  q_entry_t    ready_q[$];

  // Last result of a word is held back until we know it closes the word.
  out_word_t held_word;
  bit        held_full;

  // Stimulus control and bookkeeping.
  int unsigned idle_pct = 8;
  logic [31:0] arr_cursor;
  logic        word_taken = 1'b0;
  int unsigned err_cnt;
  int unsigned words_taken;
  int unsigned n_dispatched;
  int unsigned n_rej_full;
  int unsigned n_rej_limit;
  int unsigned stall_cycles;

  // ---------------------------------------------------------------------------
  // Shadow scheduler
  // ---------------------------------------------------------------------------

  function automatic void emit_result(input out_word_t w);
    if (held_full)
      dispatch_exp_q.push_back(held_word);
    held_word = w;
    held_full = 1'b1;
  endfunction

  // Head of the ready queue runs to completion; clock moves to its end.
  function automatic void run_head_job();
    q_entry_t    job;
    out_word_t   w;
    logic [31:0] fin;
    logic [31:0] waited;
    logic [31:0] turn;
    job    = ready_q.pop_front();
    fin    = sim_clock + 32'(job.burst);
    waited = sim_clock - job.arrival;
    turn   = fin - job.arrival;
    sim_wait_sum = sim_wait_sum + 48'(waited);
    sim_ta_sum   = sim_ta_sum + 48'(turn);
    sim_done     = sim_done + 16'd1;
    w = '0;
    w.status           = STATUS_DISPATCHED;
    w.out_job_id       = job.id;
    w.start_time       = sim_clock;
    w.end_time         = fin;
    w.wait_time        = waited;
    w.turnaround_time  = turn;
    w.total_wait       = sim_wait_sum;
    w.total_turnaround = sim_ta_sum;
    w.dispatched_count = sim_done;
    sim_clock = fin;
    emit_result(w);
  endfunction

  // Rejects carry zero times but the current totals.
  function automatic void reject_job(input logic [1:0] why, input logic [15:0] id);
    out_word_t w;
    w = '0;
    w.status           = why;
    w.out_job_id       = id;
    w.total_wait       = sim_wait_sum;
    w.total_turnaround = sim_ta_sum;
    w.dispatched_count = sim_done;
    emit_result(w);
  endfunction

  // One accepted word: dispatch, clock jump, insert or reject.
  function automatic void schedule_step(input in_word_t w);
    q_entry_t e;
    int       pos;
    held_full = 1'b0;
    if (w.cmd == CMD_DRAIN) begin
      while (ready_q.size() > 0 && sim_done < sim_limit)
        run_head_job();
    end else if (sim_done >= sim_limit) begin
      // the limit reject is tested once, up front, before any dispatch
      reject_job(STATUS_REJ_LIMIT, w.job_id);
    end else begin
      while (ready_q.size() > 0 && sim_clock < w.arrival_time && sim_done < sim_limit)
        run_head_job();
      // idle clock jumps; not when the limit stopped the dispatching
      if (ready_q.size() == 0 && sim_clock < w.arrival_time)
        sim_clock = w.arrival_time;
      if (ready_q.size() >= QUEUE_DEPTH) begin
        reject_job(STATUS_REJ_FULL, w.job_id);
      end else begin
        // stable insert: behind every entry of the same or a lower level
        e.id      = w.job_id;
        e.arrival = w.arrival_time;
        e.burst   = w.burst_length;
        e.level   = w.prio_level;
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].level <= w.prio_level)
          pos++;
        ready_q.insert(pos, e);
      end
    end
    if (held_full) begin
      held_word.last = 1'b1;
      dispatch_exp_q.push_back(held_word);
      held_full = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new word at the falling edge once the previous one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // hold the word until the scheduler takes it
    end else if (req_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
      item  <= req_q.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on acceptance first, then check any result; results
  // come in order, so the expectation queue stays in step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      word_taken   <= 1'b0;
      sim_clock    = '0;
      sim_wait_sum = '0;
      sim_ta_sum   = '0;
      sim_done     = '0;
      sim_limit    = MAX_DISPATCH_RST;
      ready_q.delete();
      dispatch_exp_q.delete();
    end else begin
      word_taken <= start && !busy;
      if (cfg_we)
        sim_limit = cfg_wdata;
      if (start && !busy) begin
        words_taken++;
        schedule_step(item);
      end
      if (result_valid) begin
        if (dispatch_exp_q.size() == 0) begin
          $error("result with nothing pending: job 0x%0h status %0d",
                 result.out_job_id, result.status);
          err_cnt++;
        end else begin
          want = dispatch_exp_q.pop_front();
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("out_job_id", 64'(want.out_job_id), 64'(result.out_job_id));
          check_field("start_time", 64'(want.start_time), 64'(result.start_time));
          check_field("end_time", 64'(want.end_time), 64'(result.end_time));
          check_field("wait_time", 64'(want.wait_time), 64'(result.wait_time));
          check_field("turnaround_time", 64'(want.turnaround_time),
                      64'(result.turnaround_time));
          check_field("total_wait", 64'(want.total_wait), 64'(result.total_wait));
          check_field("total_turnaround", 64'(want.total_turnaround),
                      64'(result.total_turnaround));
          check_field("dispatched_count", 64'(want.dispatched_count),
                      64'(result.dispatched_count));
          check_field("last", 64'(want.last), 64'(result.last));
          case (want.status)
            STATUS_DISPATCHED: n_dispatched++;
            STATUS_REJ_FULL:   n_rej_full++;
            default:           n_rej_limit++;
          endcase
        end
      end
    end
  end

  // Watchdog: too long with neither a word taken nor a result seen.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("** nonpreemptive_priority_scheduler_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_arrival(input logic [15:0] id, input logic [31:0] t,
                               input logic [15:0] burst, input logic [7:0] lvl);
    in_word_t w;
    w.cmd          = CMD_ARRIVE;
    w.job_id       = id;
    w.arrival_time = t;
    w.burst_length = burst;
    w.prio_level   = lvl;
    req_q.push_back(w);
  endtask

  // Drain ignores the other fields, so they get noise.
  task automatic queue_drain();
    in_word_t w;
    w.cmd          = CMD_DRAIN;
    w.job_id       = 16'($urandom_range(65535, 0));
    w.arrival_time = $urandom;
    w.burst_length = 16'($urandom_range(65535, 0));
    w.prio_level   = 8'($urandom_range(255, 0));
    req_q.push_back(w);
  endtask

  // Returns at a falling edge with everything taken, answered and settled.
  task automatic wait_quiet();
    do
      @(negedge clk);
    while (req_q.size() != 0 || start || busy || dispatch_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed arrival streams: times move forward from the cursor,
  // with same-tick ties, long idle jumps, a few late (earlier) arrivals and
  // an occasional drain.
  task automatic add_random_words(input int n);
    int unsigned roll;
    logic [31:0] step;
    logic [31:0] t;
    logic [15:0] burst;
    logic [7:0]  lvl;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 6) begin
        queue_drain();
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 15)
          step = '0;
        else if (roll < 90)
          step = $urandom_range(160, 1);
        else
          step = $urandom_range(70000, 1);
        if ($urandom_range(99, 0) < 5) begin
          t = arr_cursor - $urandom_range(400, 0);
        end else begin
          arr_cursor = arr_cursor + step;
          t = arr_cursor;
        end
        burst = ($urandom_range(99, 0) < 90) ? 16'($urandom_range(120, 0))
                                              : 16'($urandom_range(65535, 0));
        lvl   = ($urandom_range(99, 0) < 60) ? 8'($urandom_range(3, 0))
                                              : 8'($urandom_range(255, 0));
        queue_arrival(16'($urandom_range(65535, 0)), t, burst, lvl);
      end
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset limit of 500.
    // Field extremes, both at tick zero; the first lands on an empty queue.
    queue_arrival(16'h0000, 32'd0, 16'd0, 8'd0);
    queue_arrival(16'hFFFF, 32'd0, 16'hFFFF, 8'hFF);
    // Later arrival dispatches both first, then queues.
    queue_arrival(16'h0101, 32'd5, 16'd10, 8'h80);
    // Earlier arrivals with level ties fill the queue; one more is refused.
    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
      queue_arrival(16'h0200 + 16'(k), 32'h100, 16'h2000, 8'(k % 4));
    queue_arrival(16'hBEEF, 32'h100, 16'd1, 8'd0);
    // Dispatch stops once the clock passes the arrival, queue left part full.
    queue_arrival(16'h0300, 32'h0002_0000, 16'd5, 8'd2);
    queue_drain();
    // Idle jump near the top of time, then wrap of the end time.
    queue_arrival(16'h7777, 32'hFFFF_FF00, 16'h1000, 8'd5);
    queue_arrival(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    queue_drain();
    wait_quiet();

    // Limit of zero: arrivals refused, drain does nothing.
    write_limit(16'd0);
    queue_arrival(16'h1234, 32'h0001_0000, 16'd3, 8'd1);
    queue_drain();
    wait_quiet();

    // Limit reached in the middle of a dispatch run: no clock jump, the
    // arrival still queued, then refusals and an empty drain.
    write_limit(sim_done + 16'd2);
    queue_arrival(16'h0401, 32'd0, 16'd20, 8'd9);
    queue_arrival(16'h0402, 32'd0, 16'd30, 8'd4);
    queue_arrival(16'h0403, 32'd0, 16'd40, 8'd9);
    queue_arrival(16'h0404, 32'h0004_0000, 16'd50, 8'd1);
    queue_arrival(16'h0405, 32'h0004_0000, 16'd50, 8'd1);
    queue_drain();
    wait_quiet();

    // Random, no limit in reach, sender mostly busy.
    write_limit(16'hFFFF);
    arr_cursor = sim_clock;
    add_random_words(125);
    wait_quiet();

    // Random, limit reached partway, sender often idle; pause in the middle
    // until every owed result is out.
    idle_pct = 59;
    write_limit(sim_done + 16'd50);
    arr_cursor = sim_clock;
    add_random_words(60);
    wait_quiet();
    add_random_words(60);
    wait_quiet();

    // Random, back to the widest limit, no idling.
    idle_pct = 0;
    write_limit(16'hFFFF);
    arr_cursor = sim_clock;
    add_random_words(95);
    wait_quiet();

    $display("Covered %0d words: %0d jobs dispatched, %0d refused on a full queue, %0d at the limit",
             words_taken, n_dispatched, n_rej_full, n_rej_limit);
    $display("Limits 500, 0, a mid-run stop and 65535; sender idle 8, 59 and 0 percent");
    if (err_cnt == 0) begin
      $display("** nonpreemptive_priority_scheduler_top: PASSED **");
    end else begin
      $display("** nonpreemptive_priority_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
